@@ rtl/ugbs_pkg.sv @@
// Shared types, codes and constants for the uniform grid bucket store.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package ugbs_pkg;

  localparam int MAX_CELLS_DEF     = 256;
  localparam int CELL_CAPACITY_DEF = 16;
  localparam int HANDLE_BITS_DEF   = 32;
  localparam int COORD_BITS_DEF    = 16;

  localparam int MODE_W    = 2;
  localparam int LOC_W     = 4;
  localparam int DIM_W     = 5;
  localparam int SPAN_W    = 16;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 5;
  localparam int IDX_W     = 10;
  localparam int IDX_CMP_W = 13;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] ADDR_COLUMNS = 4'h0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_ROWS    = 4'h4;
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPAN    = 4'h8;

  localparam logic [DIM_W-1:0]  COLUMNS_RST = 5'd16;
  localparam logic [DIM_W-1:0]  ROWS_RST    = 5'd16;
  localparam logic [SPAN_W-1:0] SPAN_RST    = 16'd256;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT   = 2'd0,
    MODE_REMOVE   = 2'd1,
    MODE_CONTAINS = 2'd2,
    MODE_SIZE     = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_NOT_FOUND   = 3'd1,
    ST_FULL        = 3'd2,
    ST_ZERO_HANDLE = 3'd3,
    ST_RANGE       = 3'd4
  } status_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_sel_y;
    logic cap_x;
    logic cap_y;
    logic locate;
    logic n_cap;
    logic k_clr;
    logic scan_rd;
    logic scan_cmp;
    logic ins_wr;
    logic cnt_wr;
    logic res_load;
    logic clr_wr;
  } cmd_t;

  typedef struct packed {
    logic pos_mode;
    logic is_insert;
    logic is_remove;
    logic is_contains;
    logic div_done;
    logic range_ok;
    logic h_zero;
    logic full;
    logic k_end;
    logic hit;
    logic found;
    logic out_free;
    logic clr_last;
  } sts_t;

endpackage

@@ rtl/ugbs_if.sv @@
// Input and result channel interfaces of the grid bucket store.
// Depends on ugbs_pkg.
`timescale 1ns / 1ps

interface ugbs_in_if import ugbs_pkg::*; #(
  parameter int HANDLE_BITS = HANDLE_BITS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [MODE_W-1:0]      mode;
  logic [COORD_BITS-1:0]  pos_x;
  logic [COORD_BITS-1:0]  pos_y;
  logic [LOC_W-1:0]       cell_column;
  logic [LOC_W-1:0]       cell_row;
  logic [HANDLE_BITS-1:0] handle;

  modport source (output valid, mode, pos_x, pos_y, cell_column, cell_row, handle,
                  input ready);
  modport sink   (input valid, mode, pos_x, pos_y, cell_column, cell_row, handle,
                  output ready);
endinterface

interface ugbs_out_if import ugbs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, found, entry_count, input ready);
  modport sink   (input valid, status, found, entry_count, output ready);
endinterface

@@ rtl/ugbs_div.sv @@
// Restoring divider, one quotient bit per cycle, for coordinate / span.
// Depends on ugbs_pkg.
`timescale 1ns / 1ps

module ugbs_div import ugbs_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [COORD_BITS-1:0] dividend,
  input  logic [SPAN_W-1:0]     divisor,
  output logic                  done,
  output logic [COORD_BITS-1:0] quotient
);

  localparam int CW = $clog2(COORD_BITS + 1);

  logic [COORD_BITS-1:0] dvd_r;
  logic [COORD_BITS-1:0] q_r;
  logic [SPAN_W-1:0]     rem_r;
  logic [CW-1:0]         cnt_r;
  logic                  run_r;
  logic                  done_r;

  logic [SPAN_W:0] trial;
  logic [SPAN_W:0] diff;
  logic            ge;

  always_comb begin
    trial = {rem_r, dvd_r[COORD_BITS-1]};
    diff  = trial - {1'b0, divisor};
    ge    = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(COORD_BITS);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (run_r) begin
      dvd_r <= dvd_r << 1;
      q_r   <= {q_r[COORD_BITS-2:0], ge};
      rem_r <= ge ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

@@ rtl/ugbs_dp.sv @@
// Datapath: item registers, cell locate, count and handle memories, result register.
// Depends on ugbs_pkg and ugbs_div; driven by ugbs_ctrl commands.
`timescale 1ns / 1ps

module ugbs_dp import ugbs_pkg::*; #(
  parameter int MAX_CELLS     = MAX_CELLS_DEF,
  parameter int CELL_CAPACITY = CELL_CAPACITY_DEF,
  parameter int HANDLE_BITS   = HANDLE_BITS_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [MODE_W-1:0]      in_mode,
  input  logic [COORD_BITS-1:0]  in_pos_x,
  input  logic [COORD_BITS-1:0]  in_pos_y,
  input  logic [LOC_W-1:0]       in_cell_column,
  input  logic [LOC_W-1:0]       in_cell_row,
  input  logic [HANDLE_BITS-1:0] in_handle,
  input  logic [DIM_W-1:0]       grid_columns,
  input  logic [DIM_W-1:0]       grid_rows,
  input  logic [SPAN_W-1:0]      cell_span,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [STATUS_W-1:0]    out_status,
  output logic                   out_found,
  output logic [COUNT_W-1:0]     out_entry_count
);

  localparam int DEPTH = MAX_CELLS * CELL_CAPACITY;
  localparam int CIW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(CELL_CAPACITY + 1);

  // item registers
  mode_t                  mode_r;
  logic [COORD_BITS-1:0]  posx_r, posy_r;
  logic [LOC_W-1:0]       col_in_r, row_in_r;
  logic [HANDLE_BITS-1:0] h_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= mode_t'(in_mode);
      posx_r   <= in_pos_x;
      posy_r   <= in_pos_y;
      col_in_r <= in_cell_column;
      row_in_r <= in_cell_row;
      h_r      <= in_handle;
    end
  end

  logic pos_mode;
  assign pos_mode = (mode_r == MODE_INSERT) || (mode_r == MODE_REMOVE);

  // coordinate divisions share one divider
  logic                  div_done;
  logic [COORD_BITS-1:0] div_q;
  logic [COORD_BITS-1:0] qx_r, qy_r;

  ugbs_div #(.COORD_BITS(COORD_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (cmd.div_sel_y ? posy_r : posx_r),
    .divisor  (cell_span),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap_x) qx_r <= div_q;
    if (cmd.cap_y) qy_r <= div_q;
  end

  // cell locate
  logic [COORD_BITS-1:0] col_src, row_src;
  logic [IDX_W-1:0]      idx;
  logic                  in_rng;
  logic [CIW-1:0]        cell_r;
  logic                  range_ok_r;

  always_comb begin
    col_src = pos_mode ? qx_r : COORD_BITS'(col_in_r);
    row_src = pos_mode ? qy_r : COORD_BITS'(row_in_r);
    idx     = IDX_W'(col_src[DIM_W-1:0]) * IDX_W'(grid_rows) + IDX_W'(row_src[DIM_W-1:0]);
    in_rng  = (col_src < COORD_BITS'(grid_columns)) && (row_src < COORD_BITS'(grid_rows)) &&
              (IDX_CMP_W'(idx) < IDX_CMP_W'(MAX_CELLS)) &&
              (!pos_mode || (cell_span != '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_ok_r <= 1'b0;
    end else if (cmd.locate) begin
      range_ok_r <= in_rng;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.locate) cell_r <= CIW'(idx);
  end

  // per-cell counts, cleared by a sweep after reset
  logic [CNTW-1:0] cnt_mem [MAX_CELLS];
  logic [CNTW-1:0] cnt_q;
  logic [CNTW-1:0] n_r;
  logic [CIW-1:0]  clr_r;
  logic [CIW-1:0]  cnt_wa;
  logic [CNTW-1:0] cnt_wd;

  always_comb begin
    cnt_wa = cmd.clr_wr ? clr_r : cell_r;
    if (cmd.clr_wr)                 cnt_wd = '0;
    else if (mode_r == MODE_INSERT) cnt_wd = n_r + 1'b1;
    else                            cnt_wd = n_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr || cmd.cnt_wr) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_q <= cnt_mem[cell_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.n_cap) n_r <= cnt_q;
  end

  // handle store and scan
  logic [HANDLE_BITS-1:0] h_mem [DEPTH];
  logic [HANDLE_BITS-1:0] rd_q;
  logic [AW-1:0]          base;
  logic [CNTW-1:0]        k_r;
  logic                   found_r;
  logic                   shift_wr;
  logic                   hw_en;
  logic [AW-1:0]          hw_addr;
  logic [HANDLE_BITS-1:0] hw_data;

  always_comb begin
    base     = AW'(cell_r) * AW'(CELL_CAPACITY);
    shift_wr = cmd.scan_cmp && found_r && (mode_r == MODE_REMOVE);
    hw_en    = cmd.ins_wr || shift_wr;
    hw_addr  = cmd.ins_wr ? base + AW'(n_r) : base + AW'(k_r) - 1'b1;
    hw_data  = cmd.ins_wr ? h_r : rd_q;
  end

  always_ff @(posedge clk) begin
    if (hw_en) h_mem[hw_addr] <= hw_data;
    if (cmd.scan_rd) rd_q <= h_mem[base + AW'(k_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      found_r <= 1'b0;
    end else if (cmd.k_clr) begin
      k_r     <= '0;
      found_r <= 1'b0;
    end else if (cmd.scan_cmp) begin
      k_r <= k_r + 1'b1;
      if (rd_q == h_r) found_r <= 1'b1;
    end
  end

  // result
  logic                valid_r;
  status_t             status_r;
  logic                found_o_r;
  logic [COUNT_W-1:0]  count_r;
  status_t             res_status;
  logic                res_found;
  logic [CNTW:0]       res_count;
  logic                full_n;

  always_comb begin
    full_n     = n_r >= CNTW'(CELL_CAPACITY);
    res_status = ST_OK;
    res_found  = 1'b0;
    res_count  = {1'b0, n_r};
    if (!range_ok_r) begin
      res_status = ST_RANGE;
      res_count  = '0;
    end else begin
      case (mode_r)
        MODE_INSERT: begin
          if (h_r == '0)  res_status = ST_ZERO_HANDLE;
          else if (full_n) res_status = ST_FULL;
          else            res_count  = {1'b0, n_r} + 1'b1;
        end
        MODE_REMOVE: begin
          res_found = found_r;
          if (found_r) res_count  = {1'b0, n_r} - 1'b1;
          else         res_status = ST_NOT_FOUND;
        end
        MODE_CONTAINS: begin
          res_found = found_r;
          if (!found_r) res_status = ST_NOT_FOUND;
        end
        default: res_status = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status_r  <= res_status;
      found_o_r <= res_found;
      count_r   <= COUNT_W'(res_count);
    end
  end

  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_found       = found_o_r;
  assign out_entry_count = count_r;

  always_comb begin
    sts.pos_mode    = pos_mode;
    sts.is_insert   = mode_r == MODE_INSERT;
    sts.is_remove   = mode_r == MODE_REMOVE;
    sts.is_contains = mode_r == MODE_CONTAINS;
    sts.div_done    = div_done;
    sts.range_ok    = range_ok_r;
    sts.h_zero      = h_r == '0;
    sts.full        = cnt_q >= CNTW'(CELL_CAPACITY);
    sts.k_end       = k_r >= n_r;
    sts.hit         = rd_q == h_r;
    sts.found       = found_r;
    sts.out_free    = !valid_r || out_ready;
    sts.clr_last    = clr_r == CIW'(MAX_CELLS - 1);
  end

endmodule

@@ rtl/ugbs_ctrl.sv @@
// Controller state machine: sequences divide, locate, scan, update and result.
// Depends on ugbs_pkg; drives ugbs_dp through cmd_t and reads sts_t.
`timescale 1ns / 1ps

module ugbs_ctrl import ugbs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [12:0] {
    S_CLEAR   = 13'b0000000000001,
    S_IDLE    = 13'b0000000000010,
    S_DIVX    = 13'b0000000000100,
    S_DIVXW   = 13'b0000000001000,
    S_DIVY    = 13'b0000000010000,
    S_DIVYW   = 13'b0000000100000,
    S_LOCATE  = 13'b0000001000000,
    S_CNTRD   = 13'b0000010000000,
    S_DECIDE  = 13'b0000100000000,
    S_SCANRD  = 13'b0001000000000,
    S_SCANCMP = 13'b0010000000000,
    S_UPDATE  = 13'b0100000000000,
    S_RESULT  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIVX;
        end
      end
      S_DIVX: begin
        if (sts.pos_mode) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIVXW;
        end else begin
          state_nxt = S_LOCATE;
        end
      end
      S_DIVXW: begin
        if (sts.div_done) begin
          cmd.cap_x = 1'b1;
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        cmd.div_start = 1'b1;
        cmd.div_sel_y = 1'b1;
        state_nxt     = S_DIVYW;
      end
      S_DIVYW: begin
        if (sts.div_done) begin
          cmd.cap_y = 1'b1;
          state_nxt = S_LOCATE;
        end
      end
      S_LOCATE: begin
        cmd.locate = 1'b1;
        state_nxt  = S_CNTRD;
      end
      S_CNTRD: state_nxt = S_DECIDE;
      S_DECIDE: begin
        cmd.n_cap = 1'b1;
        if (!sts.range_ok) begin
          state_nxt = S_RESULT;
        end else if (sts.is_insert) begin
          state_nxt = (sts.h_zero || sts.full) ? S_RESULT : S_UPDATE;
        end else if (sts.is_remove || sts.is_contains) begin
          cmd.k_clr = 1'b1;
          state_nxt = S_SCANRD;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_SCANRD: begin
        if (sts.k_end) begin
          state_nxt = (sts.is_remove && sts.found) ? S_UPDATE : S_RESULT;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = S_SCANCMP;
        end
      end
      S_SCANCMP: begin
        cmd.scan_cmp = 1'b1;
        state_nxt    = (sts.is_contains && sts.hit) ? S_RESULT : S_SCANRD;
      end
      S_UPDATE: begin
        cmd.ins_wr = sts.is_insert;
        cmd.cnt_wr = 1'b1;
        state_nxt  = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = state_r == S_IDLE;

endmodule

@@ rtl/uniform_grid_bucket_store_unit.sv @@
// Uniform grid bucket store: one item in, one result out, one item in flight.
// Insert and remove run the two span divisions in the bit-serial divider,
// then remove scans the cell's entries (search and shift share one loop
// over the single handle-memory read port); contains and size skip the
// divisions. After reset a sweep clears the per-cell counts, during which
// no item is taken; configuration writes are taken at any time. The result
// sits in an output register, so the next item can be taken while it waits.
// Depends on ugbs_pkg, ugbs_if, ugbs_div, ugbs_dp and ugbs_ctrl.
`timescale 1ns / 1ps

module uniform_grid_bucket_store_unit import ugbs_pkg::*; #(
  parameter int MAX_CELLS     = MAX_CELLS_DEF,
  parameter int CELL_CAPACITY = CELL_CAPACITY_DEF,
  parameter int HANDLE_BITS   = HANDLE_BITS_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ugbs_in_if.sink               in_ch,
  ugbs_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // --- configuration registers -------------------------------------------
  // Written in the access phase; an address off the map is dropped.
  logic [DIM_W-1:0]  columns_r;
  logic [DIM_W-1:0]  rows_r;
  logic [SPAN_W-1:0] span_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= COLUMNS_RST;
      rows_r    <= ROWS_RST;
      span_r    <= SPAN_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr)
        ADDR_COLUMNS: columns_r <= cfg_pwdata[DIM_W-1:0];
        ADDR_ROWS:    rows_r    <= cfg_pwdata[DIM_W-1:0];
        ADDR_SPAN:    span_r    <= cfg_pwdata[SPAN_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      ADDR_COLUMNS: cfg_prdata = CFG_DATA_W'(columns_r);
      ADDR_ROWS:    cfg_prdata = CFG_DATA_W'(rows_r);
      ADDR_SPAN:    cfg_prdata = CFG_DATA_W'(span_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // --- controller and datapath ---------------------------------------------
  cmd_t cmd;
  sts_t sts;

  ugbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ugbs_dp #(
    .MAX_CELLS     (MAX_CELLS),
    .CELL_CAPACITY (CELL_CAPACITY),
    .HANDLE_BITS   (HANDLE_BITS),
    .COORD_BITS    (COORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_ch.mode),
    .in_pos_x        (in_ch.pos_x),
    .in_pos_y        (in_ch.pos_y),
    .in_cell_column  (in_ch.cell_column),
    .in_cell_row     (in_ch.cell_row),
    .in_handle       (in_ch.handle),
    .grid_columns    (columns_r),
    .grid_rows       (rows_r),
    .cell_span       (span_r),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_found       (out_ch.found),
    .out_entry_count (out_ch.entry_count)
  );

  // --- assertions -------------------------------------------------------------
  // one item at a time: ready drops right after a transfer
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while an item is in flight");

  // an insert only writes a valid, non-zero handle into a located cell
  a_insert_guard: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_wr |-> sts.range_ok && !sts.h_zero && sts.is_insert)
    else $error("handle write without a legal insert");

  // no result can be produced in the cycle after a transfer
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !cmd.res_load)
    else $error("result loaded straight after transfer");

endmodule

@@ dv/tb_uniform_grid_bucket_store_unit.sv @@
// Self-checking bench for the uniform grid bucket store: directed items and
// random bursts, a local model of the cell lists and counts, in-order compare.
// Depends on ugbs_pkg, ugbs_if and the store top level.
`timescale 1ns / 1ps

module tb_uniform_grid_bucket_store_unit;
  import ugbs_pkg::*;

  localparam int NCELLS = MAX_CELLS_DEF;
  localparam int CAP    = CELL_CAPACITY_DEF;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [3:0]  col;
    logic [3:0]  row;
    logic [31:0] handle;
  } op_t;

  typedef struct packed {
    status_t    status;
    logic       found;
    logic [4:0] count;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ugbs_in_if  in_ch ();
  ugbs_out_if out_ch ();

  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  uniform_grid_bucket_store_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state: grid shape, span, per-cell lists
  logic [4:0]  m_cols = 5'd16;
  logic [4:0]  m_rows = 5'd16;
  logic [15:0] m_span = 16'd256;
  logic [31:0] m_lists [NCELLS][CAP];
  int          m_count [NCELLS];

  op_t    pending_ops [$];
  reply_t awaited [$];
  int     err_count = 0;
  bit     hold_off = 1'b0;

  // Compute the reply for one accepted item and update the model lists
  function automatic reply_t bucket_apply(op_t op);
    reply_t r;
    int c, rw, cidx, at;
    bit ok;
    r = '{status: ST_OK, found: 1'b0, count: 5'd0};
    if (op.mode == MODE_INSERT || op.mode == MODE_REMOVE) begin
      ok = (m_span != 0);
      if (ok) begin
        c  = op.pos_x / m_span;
        rw = op.pos_y / m_span;
      end
    end else begin
      ok = 1'b1;
      c  = op.col;
      rw = op.row;
    end
    if (ok) begin
      ok = (c < m_cols) && (rw < m_rows);
      cidx = c * m_rows + rw;
      ok = ok && (cidx < NCELLS);
    end
    if (!ok) begin
      r.status = ST_RANGE;
      return r;
    end
    at = -1;
    for (int k = 0; k < m_count[cidx]; k++)
      if (at < 0 && m_lists[cidx][k] == op.handle) at = k;
    case (op.mode)
      MODE_INSERT: begin
        if (op.handle == 0) r.status = ST_ZERO_HANDLE;
        else if (m_count[cidx] >= CAP) r.status = ST_FULL;
        else begin
          m_lists[cidx][m_count[cidx]] = op.handle;
          m_count[cidx]++;
        end
      end
      MODE_REMOVE: begin
        if (at < 0) r.status = ST_NOT_FOUND;
        else begin
          for (int k = at; k + 1 < m_count[cidx]; k++)
            m_lists[cidx][k] = m_lists[cidx][k + 1];
          m_count[cidx]--;
          r.found = 1'b1;
        end
      end
      MODE_CONTAINS: begin
        if (at < 0) r.status = ST_NOT_FOUND;
        else r.found = 1'b1;
      end
      default: ;
    endcase
    r.count = 5'(m_count[cidx]);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // Driver: bursts with random gaps; hold_off freezes it for the mid-phase pause.
  // pending_ops[0] is the item on the wire while valid is high.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.mode        <= MODE_INSERT;
      in_ch.pos_x       <= '0;
      in_ch.pos_y       <= '0;
      in_ch.cell_column <= '0;
      in_ch.cell_row    <= '0;
      in_ch.handle      <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) awaited.push_back(bucket_apply(pending_ops.pop_front()));
      if (hold_off || pending_ops.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else begin
        op_t nx;
        nx = pending_ops[0];
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= nx.mode;
        in_ch.pos_x       <= nx.pos_x;
        in_ch.pos_y       <= nx.pos_y;
        in_ch.cell_column <= nx.col;
        in_ch.cell_row    <= nx.row;
        in_ch.handle      <= nx.handle;
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 12);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        end
      end
    end
  end

  // Monitor and receiver stall pattern
  int stall_phase = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited.size() == 0) begin
          report_mismatch("unexpected transfer", 1, 0);
        end else begin
          reply_t w;
          w = awaited.pop_front();
          if (out_ch.status != w.status)
            report_mismatch("status", int'(out_ch.status), int'(w.status));
          if (out_ch.found != w.found)
            report_mismatch("found", int'(out_ch.found), int'(w.found));
          if (out_ch.entry_count != w.count)
            report_mismatch("entry_count", int'(out_ch.entry_count), int'(w.count));
        end
      end
      stall_phase <= (stall_phase + 1) % 97;
      if (stall_phase < 40) out_ch.ready <= 1'b1;
      else if (stall_phase < 70) out_ch.ready <= ($urandom_range(0, 2) != 0);
      else out_ch.ready <= ($urandom_range(0, 4) == 0);
    end
  end

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= addr; cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (addr == ADDR_COLUMNS) m_cols = data[4:0];
    else if (addr == ADDR_ROWS) m_rows = data[4:0];
    else if (addr == ADDR_SPAN) m_span = data[15:0];
  endtask

  // Block until every queued item has gone and every reply has been checked
  task automatic drain();
    while (pending_ops.size() != 0 || in_ch.valid || awaited.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic op_t rand_op(input int hpool, input int pos_limit);
    op_t o;
    o.mode   = mode_t'($urandom_range(0, 9) < 5 ? MODE_INSERT : $urandom_range(1, 3));
    o.pos_x  = 16'($urandom_range(0, pos_limit));
    o.pos_y  = 16'($urandom_range(0, pos_limit));
    o.col    = 4'($urandom_range(0, 15));
    o.row    = 4'($urandom_range(0, 15));
    // small handle pool so removes and contains hit; occasionally wide or zero
    case ($urandom_range(0, 19))
      0:       o.handle = 32'd0;
      1:       o.handle = $urandom();
      default: o.handle = $urandom_range(1, hpool);
    endcase
    return o;
  endfunction

  task automatic push(input mode_t m, input int px, input int py, input int c,
                      input int r, input logic [31:0] h);
    op_t o;
    o = '{mode: m, pos_x: 16'(px), pos_y: 16'(py), col: 4'(c), row: 4'(r), handle: h};
    pending_ops.push_back(o);
  endtask

  initial begin
    foreach (m_count[i]) m_count[i] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every mode, zero handle, full cell, misses
    push(MODE_INSERT, 0, 0, 0, 0, 32'hFFFF_FFFF);
    push(MODE_INSERT, 16'hFFFF, 16'hFFFF, 0, 0, 32'h1);
    push(MODE_INSERT, 16'h0100, 0, 0, 0, 32'd0);
    push(MODE_CONTAINS, 0, 0, 0, 0, 32'hFFFF_FFFF);
    push(MODE_CONTAINS, 0, 0, 15, 15, 32'h5);
    push(MODE_SIZE, 0, 0, 15, 15, 0);
    push(MODE_SIZE, 0, 0, 0, 0, 0);
    for (int i = 1; i <= 17; i++) push(MODE_INSERT, 16'h0F00, 16'h0FFF, 0, 0, i);
    push(MODE_REMOVE, 16'h0F00, 16'h0FFF, 0, 0, 32'd8);
    push(MODE_REMOVE, 16'h0F00, 16'h0FFF, 0, 0, 32'd99);
    push(MODE_SIZE, 0, 0, 15, 15, 0);
    push(MODE_REMOVE, 0, 0, 0, 0, 32'hFFFF_FFFF);
    drain();

    // Random phases across grid shapes and spans, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      int cols, rows, span, n;
      case (ph)
        0: begin cols = 16; rows = 16; span = 256; end
        1: begin cols = 1; rows = 1; span = 65535; end
        2: begin cols = 3; rows = 5; span = 1; end
        3: begin cols = 31; rows = 31; span = 4096; end
        4: begin cols = 16; rows = 16; span = 0; end
        5: begin cols = 0; rows = 7; span = 100; end
        default: begin
          cols = $urandom_range(0, 31); rows = $urandom_range(0, 31);
          span = $urandom_range(1, 65535);
        end
      endcase
      cfg_write(ADDR_COLUMNS, {$urandom() & 32'hFFFF_FFE0} | cols);
      cfg_write(ADDR_ROWS, rows);
      cfg_write(ADDR_SPAN, {$urandom_range(0, 1) ? 16'hFFFF : 16'h0, 16'(span)});
      n = 230;
      for (int i = 0; i < n; i++)
        pending_ops.push_back(rand_op(ph == 1 ? 40 : 24,
          (span == 0) ? 65535 : ((cols * span + span) > 65535 ? 65535 : cols * span + span)));
      // mid-phase pause until all replies are in
      while (pending_ops.size() > n / 2) @(posedge clk);
      hold_off = 1'b1;
      while (in_ch.valid || awaited.size() != 0) @(posedge clk);
      hold_off = 1'b0;
      drain();
    end

    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
